### hdl/iss_pkg.sv
package iss_pkg;

  localparam int unsigned SqSteps  = 33;  // root bits of a 66-bit radicand
  localparam int unsigned DivSteps = 64;  // quotient bits of a 64-bit dividend
  localparam int unsigned NLanes   = 7;   // three accel lanes, four quaternion lanes

  localparam logic [31:0] QOne    = 32'd65536;
  localparam logic [32:0] NormHi  = 33'd65602;  // 1.0 + tolerance
  localparam logic [32:0] NormLo  = 33'd65470;  // 1.0 - tolerance
  localparam logic [30:0] GyroLimRst  = 31'd2293760;
  localparam logic [30:0] AccelLimRst = 31'd12858163;

  typedef enum logic [1:0] {
    REG_GYRO_LIMIT  = 2'd0,
    REG_ACCEL_LIMIT = 2'd1
  } reg_idx_e;

  // sample fields carried to the end of the pipe
  typedef struct packed {
    logic [2:0][31:0] rate;
    logic             rate_zero;
    logic [2:0][31:0] acc;
    logic [2:0]       acc_neg;
    logic             acc_clamp;
    logic [3:0][31:0] quat;
    logic [3:0]       quat_neg;
    logic             quat_nz;
  } smp_t;

  typedef struct packed {
    smp_t             s;
    logic [9:0][31:0] mag;
  } st1_t;

  typedef struct packed {
    smp_t             s;
    logic [9:0][63:0] sq;
    logic [2:0][62:0] prod;
    logic [61:0]      glim2;
    logic [61:0]      alim2;
    logic [3:0][31:0] qmag;
  } st2_t;

  typedef struct packed {
    smp_t                    s;
    logic [1:0][65:0]        rad;
    logic [1:0][35:0]        rem;
    logic [1:0][32:0]        root;
    logic [NLanes-1:0][63:0] dvd;
  } sqs_t;

  typedef struct packed {
    smp_t                    s;
    logic                    quat_fix;
    logic [1:0][32:0]        dsr;
    logic [NLanes-1:0][63:0] dvd;
    logic [NLanes-1:0][32:0] rem;
    logic [NLanes-1:0][31:0] quo;
  } divs_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] apply_sign(input logic [31:0] m, input logic neg);
    return neg ? (~m + 32'd1) : m;
  endfunction

endpackage

### hdl/imu_sample_sanitiser_unit.sv
// IMU sample sanitizer. Each transaction carries one sample (gyro, accel,
// quaternion, orientation-unknown flag, all signed Q16.16) and yields one
// result transaction. The gyro vector is zeroed when its magnitude is over
// gyro_limit; the accel vector is scaled by accel_limit / |a| when over
// accel_limit; the quaternion (identity when orientation is unknown) is
// divided by its norm when that norm is nonzero and more than 1e-3 off
// unity. A new sample is accepted every cycle unless the output stalls,
// and passes three front stages (magnitude, squares and products, sums and
// compares), the 33-step square-root pipe, the 64-step restoring divider
// pipe and the output register. The whole pipe advances, and in_ready_o is
// high, whenever the output register is empty or being taken. Limits are
// written through the cfg port (index 0 gyro, 1 accel; other indexes are
// ignored), by the user only while idle; the block does not enforce this.
module imu_sample_sanitiser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] rate_x_i,
  input  logic signed [31:0] rate_y_i,
  input  logic signed [31:0] rate_z_i,
  input  logic signed [31:0] acc_x_i,
  input  logic signed [31:0] acc_y_i,
  input  logic signed [31:0] acc_z_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic signed [31:0] quat_w_i,
  input  logic               orientation_unknown_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_rate_x_o,
  output logic signed [31:0] out_rate_y_o,
  output logic signed [31:0] out_rate_z_o,
  output logic signed [31:0] out_acc_x_o,
  output logic signed [31:0] out_acc_y_o,
  output logic signed [31:0] out_acc_z_o,
  output logic signed [31:0] out_quat_x_o,
  output logic signed [31:0] out_quat_y_o,
  output logic signed [31:0] out_quat_z_o,
  output logic signed [31:0] out_quat_w_o,
  output logic               rate_zeroed_o,
  output logic               acc_clamped_o
);

  localparam int unsigned SQ = iss_pkg::SqSteps;
  localparam int unsigned DV = iss_pkg::DivSteps;
  localparam int unsigned NL = iss_pkg::NLanes;

  logic [30:0] gyro_lim_q, accel_lim_q;

  // pipeline enable: hold everything while the output waits
  logic en;

  logic            v1_q, v2_q;
  iss_pkg::st1_t   s1_d, s1_q;
  iss_pkg::st2_t   s2_d, s2_q;
  logic            sqv_q [SQ+1];
  iss_pkg::sqs_t   sq0_d;
  iss_pkg::sqs_t   sq_d  [1:SQ];
  iss_pkg::sqs_t   sq_q  [SQ+1];
  logic            dvv_q [DV+1];
  iss_pkg::divs_t  dv0_d;
  iss_pkg::divs_t  dv_d  [1:DV];
  iss_pkg::divs_t  dv_q  [DV+1];

  logic                 out_valid_q;
  logic [2:0][31:0]     orate_d, orate_q;
  logic [2:0][31:0]     oacc_d, oacc_q;
  logic [3:0][31:0]     oquat_d, oquat_q;
  logic                 ozero_q, oclamp_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_lim_q  <= iss_pkg::GyroLimRst;
      accel_lim_q <= iss_pkg::AccelLimRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        iss_pkg::REG_GYRO_LIMIT:  gyro_lim_q  <= cfg_data_i[30:0];
        iss_pkg::REG_ACCEL_LIMIT: accel_lim_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stage 1: pick quaternion, take magnitudes and signs
  always_comb begin
    logic [3:0][31:0] q;
    if (orientation_unknown_i) begin
      q = {iss_pkg::QOne, 32'd0, 32'd0, 32'd0};
    end else begin
      q = {quat_w_i, quat_z_i, quat_y_i, quat_x_i};
    end
    s1_d           = '0;
    s1_d.s.rate    = {rate_z_i, rate_y_i, rate_x_i};
    s1_d.s.acc     = {acc_z_i, acc_y_i, acc_x_i};
    s1_d.s.quat    = q;
    for (int i = 0; i < 3; i++) begin
      s1_d.s.acc_neg[i] = s1_d.s.acc[i][31];
      s1_d.mag[i]       = iss_pkg::mag32(s1_d.s.rate[i]);
      s1_d.mag[3+i]     = iss_pkg::mag32(s1_d.s.acc[i]);
    end
    for (int i = 0; i < 4; i++) begin
      s1_d.s.quat_neg[i] = q[i][31];
      s1_d.mag[6+i]      = iss_pkg::mag32(q[i]);
    end
  end

  // stage 2: squares, accel products, squared limits
  always_comb begin
    s2_d.s = s1_q.s;
    for (int i = 0; i < 10; i++) begin
      s2_d.sq[i] = {32'd0, s1_q.mag[i]} * {32'd0, s1_q.mag[i]};
    end
    for (int i = 0; i < 3; i++) begin
      s2_d.prod[i] = {31'd0, s1_q.mag[3+i]} * {32'd0, accel_lim_q};
    end
    for (int i = 0; i < 4; i++) begin
      s2_d.qmag[i] = s1_q.mag[6+i];
    end
    s2_d.glim2 = {31'd0, gyro_lim_q} * {31'd0, gyro_lim_q};
    s2_d.alim2 = {31'd0, accel_lim_q} * {31'd0, accel_lim_q};
  end

  // stage 3: sums and limit compares, load the root pipe
  always_comb begin
    logic [63:0] gsum, asum;
    logic [64:0] qsum;
    gsum = s2_q.sq[0] + s2_q.sq[1] + s2_q.sq[2];
    asum = s2_q.sq[3] + s2_q.sq[4] + s2_q.sq[5];
    qsum = {1'b0, s2_q.sq[6]} + {1'b0, s2_q.sq[7]} + {1'b0, s2_q.sq[8]} + {1'b0, s2_q.sq[9]};
    sq0_d             = '0;
    sq0_d.s           = s2_q.s;
    sq0_d.s.rate_zero = gsum > {2'b00, s2_q.glim2};
    sq0_d.s.acc_clamp = asum > {2'b00, s2_q.alim2};
    sq0_d.s.quat_nz   = qsum != 65'd0;
    sq0_d.rad[0]      = {2'b00, asum};
    sq0_d.rad[1]      = {1'b0, qsum};
    for (int i = 0; i < 3; i++) begin
      sq0_d.dvd[i] = {1'b0, s2_q.prod[i]};
    end
    for (int i = 0; i < 4; i++) begin
      sq0_d.dvd[3+i] = {16'd0, s2_q.qmag[i], 16'd0};
    end
  end

  // root pipe: one root bit per stage, two lanes
  always_comb begin
    logic [35:0] tr, tt;
    for (int k = 0; k < SQ; k++) begin
      sq_d[k+1] = sq_q[k];
      for (int l = 0; l < 2; l++) begin
        tr = {sq_q[k].rem[l][33:0], sq_q[k].rad[l][65:64]};
        tt = {1'b0, sq_q[k].root[l], 2'b01};
        if (tr >= tt) begin
          sq_d[k+1].rem[l]  = tr - tt;
          sq_d[k+1].root[l] = {sq_q[k].root[l][31:0], 1'b1};
        end else begin
          sq_d[k+1].rem[l]  = tr;
          sq_d[k+1].root[l] = {sq_q[k].root[l][31:0], 1'b0};
        end
        sq_d[k+1].rad[l] = {sq_q[k].rad[l][63:0], 2'b00};
      end
    end
  end

  // divider entry: pick divisors, decide whether the quaternion is rescaled
  always_comb begin
    logic [32:0] norm;
    norm           = sq_q[SQ].root[1];
    dv0_d          = '0;
    dv0_d.s        = sq_q[SQ].s;
    dv0_d.dsr      = sq_q[SQ].root;
    dv0_d.dvd      = sq_q[SQ].dvd;
    dv0_d.quat_fix = sq_q[SQ].s.quat_nz && (norm >= iss_pkg::NormHi || norm <= iss_pkg::NormLo);
  end

  // divider pipe: one quotient bit per stage in every lane
  always_comb begin
    logic [33:0] tr, ds;
    for (int k = 0; k < DV; k++) begin
      dv_d[k+1] = dv_q[k];
      for (int l = 0; l < NL; l++) begin
        ds = {1'b0, (l < 3) ? dv_q[k].dsr[0] : dv_q[k].dsr[1]};
        tr = {dv_q[k].rem[l], dv_q[k].dvd[l][63]};
        if (tr >= ds) begin
          dv_d[k+1].rem[l] = 33'(tr - ds);
          dv_d[k+1].quo[l] = {dv_q[k].quo[l][30:0], 1'b1};
        end else begin
          dv_d[k+1].rem[l] = tr[32:0];
          dv_d[k+1].quo[l] = {dv_q[k].quo[l][30:0], 1'b0};
        end
        dv_d[k+1].dvd[l] = {dv_q[k].dvd[l][62:0], 1'b0};
      end
    end
  end

  // output select
  always_comb begin
    iss_pkg::divs_t f;
    f = dv_q[DV];
    for (int i = 0; i < 3; i++) begin
      orate_d[i] = f.s.rate_zero ? 32'd0 : f.s.rate[i];
      oacc_d[i]  = f.s.acc_clamp ? iss_pkg::apply_sign(f.quo[i], f.s.acc_neg[i]) : f.s.acc[i];
    end
    for (int i = 0; i < 4; i++) begin
      oquat_d[i] = f.quat_fix ? iss_pkg::apply_sign(f.quo[3+i], f.s.quat_neg[i]) : f.s.quat[i];
    end
  end

  // valid bits: advance with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= SQ; k++) sqv_q[k] <= 1'b0;
      for (int k = 0; k <= DV; k++) dvv_q[k] <= 1'b0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      sqv_q[0] <= v2_q;
      for (int k = 0; k < SQ; k++) sqv_q[k+1] <= sqv_q[k];
      dvv_q[0] <= sqv_q[SQ];
      for (int k = 0; k < DV; k++) dvv_q[k+1] <= dvv_q[k];
      out_valid_q <= dvv_q[DV];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      sq_q[0] <= sq0_d;
      for (int k = 1; k <= SQ; k++) sq_q[k] <= sq_d[k];
      dv_q[0] <= dv0_d;
      for (int k = 1; k <= DV; k++) dv_q[k] <= dv_d[k];
      orate_q  <= orate_d;
      oacc_q   <= oacc_d;
      oquat_q  <= oquat_d;
      ozero_q  <= dv_q[DV].s.rate_zero;
      oclamp_q <= dv_q[DV].s.acc_clamp;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_rate_x_o  = orate_q[0];
  assign out_rate_y_o  = orate_q[1];
  assign out_rate_z_o  = orate_q[2];
  assign out_acc_x_o   = oacc_q[0];
  assign out_acc_y_o   = oacc_q[1];
  assign out_acc_z_o   = oacc_q[2];
  assign out_quat_x_o  = oquat_q[0];
  assign out_quat_y_o  = oquat_q[1];
  assign out_quat_z_o  = oquat_q[2];
  assign out_quat_w_o  = oquat_q[3];
  assign rate_zeroed_o = ozero_q;
  assign acc_clamped_o = oclamp_q;

  // an accepted sample always lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted sample lost at pipe entry");

  // a waiting result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(oacc_q) && $stable(oquat_q))
    else $error("stalled result changed");

  // zeroed gyro output is really zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rate_zeroed_o |-> orate_q == '0)
    else $error("rate flagged zeroed but nonzero");

  // a stalled pipe does not move valid bits
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dvv_q[DV]) && $stable(sqv_q[SQ]))
    else $error("pipe advanced while stalled");

endmodule
